>>> sv/csvtok_pkg.sv
// ----------------------------------------------------------------------------
// csvtok_pkg
// Shared types and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvtok_pkg;

  localparam int CSVTOK_MAX_COLUMNS = 1024;
  localparam int COL_IDX_W          = 10;
  localparam int QUEUE_DEPTH        = 4;
  localparam int CFG_IDX_W          = 3;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [7:0] RST_DELIMITER  = 8'd44;
  localparam logic [7:0] RST_QUOTE      = 8'd34;
  localparam logic [7:0] RST_ESCAPE     = 8'd34;
  localparam logic [7:0] RST_LIST_END   = 8'd93;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIMITER    = 3'd0,
    CFG_QUOTE        = 3'd1,
    CFG_ESCAPE       = 3'd2,
    CFG_LIST_END     = 3'd3,
    CFG_QUOTED_NL    = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_CONTENT   = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2,
    KIND_ROW_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_UNTERMINATED  = 3'd1,
    ERR_AFTER_QUOTE   = 3'd2,
    ERR_ESCAPE_AT_END = 3'd3,
    ERR_BAD_ESCAPE    = 3'd4,
    ERR_QUOTED_NL     = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    ST_VSTART    = 3'd0,
    ST_NORMAL    = 3'd1,
    ST_INQ       = 3'd2,
    ST_UNQ       = 3'd3,
    ST_ESC       = 3'd4,
    ST_AFTER_CR  = 3'd5,
    ST_SKIP_LINE = 3'd6,
    ST_SKIP_NL   = 3'd7
  } pstate_t;

  typedef struct packed {
    logic [7:0] delimiter;
    logic [7:0] quote_byte;
    logic [7:0] escape_byte;
    logic [7:0] list_end_byte;
    logic       allow_quoted_newline;
  } cfg_t;

  // One request: a first token and, when two is set, a row end after it.
  typedef struct packed {
    logic                 two;
    kind_t                kind;
    logic [7:0]           content_byte;
    logic [COL_IDX_W-1:0] col0;
    err_t                 err;
    logic [COL_IDX_W-1:0] col1;
  } tok_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> sv/csvtok_in_if.sv
// ----------------------------------------------------------------------------
// csvtok_in_if
// Input byte channel: one file byte or an end-of-file marker per request.
// ----------------------------------------------------------------------------
interface csvtok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_end;

  modport source (output valid, data_byte, is_end, input ready);
  modport sink   (input valid, data_byte, is_end, output ready);
endinterface

>>> sv/csvtok_out_if.sv
// ----------------------------------------------------------------------------
// csvtok_out_if
// Token result channel.
// ----------------------------------------------------------------------------
interface csvtok_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] content_byte;
  logic [9:0] column_index;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, kind, content_byte, column_index, error_code,
                  last_of_run, input ready);
  modport sink   (input valid, kind, content_byte, column_index, error_code,
                  last_of_run, output ready);
endinterface

>>> sv/csvtok_cfg_if.sv
// ----------------------------------------------------------------------------
// csvtok_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface csvtok_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] reg_index;
  logic [7:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> sv/csv_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_core
// Byte-serial CSV tokenizer with quotes, escape byte and row error recovery.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   takes one file byte per request, or an end-of-file marker
//           (is_end = 1) that flushes a pending field and resets the row.
//   out_if  gives tokens: content bytes, field ends, row ends and row errors;
//           last_of_run marks the final token caused by one input request.
//   cfg_if  writes delimiter, quote, escape, list end and quoted-newline
//           enable; write only while no token is outstanding. Always ready.
// Throughput: one input byte per cycle while the queue is not full. A byte
//   giving two tokens shows them on out_if in turn; the four-entry request
//   queue absorbs these. Path: a token goes from queue write to output
//   register load; a second token follows once the first is taken.
// Reset: rst_n synchronous, active low; config and state registers return
//   to their defaults and parsing starts at a new row.
// Stall: out_if holds its token while ready is low; in_if keeps accepting
//   until the queue fills, then drops ready.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_core #(
  parameter int MAX_COLUMNS = csvtok_pkg::CSVTOK_MAX_COLUMNS
) (
  input  logic          clk,
  input  logic          rst_n,
  csvtok_in_if.sink     in_if,
  csvtok_out_if.source  out_if,
  csvtok_cfg_if.sink    cfg_if
);

  csvtok_pkg::q_stat_t  q_stat;
  csvtok_pkg::tok_req_t push_req;
  csvtok_pkg::tok_req_t head;
  logic                 push;
  logic                 pop;

  csvtok_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg_if   (cfg_if),
    .q_stat   (q_stat),
    .push     (push),
    .push_req (push_req)
  );

  csvtok_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  csvtok_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_if (out_if)
  );

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind == csvtok_pkg::KIND_ROW_END) |-> out_if.last_of_run)
    else $error("row end not last of run");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind == csvtok_pkg::KIND_ROW_ERROR) |-> out_if.last_of_run)
    else $error("row error not last of run");

  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |->
      ((out_if.kind == csvtok_pkg::KIND_ROW_ERROR) ==
       (out_if.error_code != csvtok_pkg::ERR_NONE)))
    else $error("error code does not match token kind");

endmodule

>>> sv/csvtok_front.sv
// ----------------------------------------------------------------------------
// csvtok_front
// Config registers and parse state machine; classifies each byte into a
// token request of up to two tokens.
// ----------------------------------------------------------------------------
module csvtok_front #(
  parameter int MAX_COLUMNS = csvtok_pkg::CSVTOK_MAX_COLUMNS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  csvtok_in_if.sink            in_if,
  csvtok_cfg_if.sink           cfg_if,
  input  csvtok_pkg::q_stat_t  q_stat,
  output logic                 push,
  output csvtok_pkg::tok_req_t push_req
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLUMNS - 1);

  csvtok_pkg::cfg_t    cfg_r;
  csvtok_pkg::pstate_t state_r, state_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;

  csvtok_pkg::pstate_t ws;
  logic [COL_W-1:0]    wcol;
  logic [COL_W-1:0]    wcol_inc;
  logic [7:0]          b;
  logic                nl;
  logic                accept;
  logic                emit;
  csvtok_pkg::tok_req_t req;

  function automatic logic [csvtok_pkg::COL_IDX_W-1:0] to_idx(input logic [COL_W-1:0] c);
    logic [COL_W+csvtok_pkg::COL_IDX_W-1:0] wide;
    wide = {{csvtok_pkg::COL_IDX_W{1'b0}}, c};
    return wide[csvtok_pkg::COL_IDX_W-1:0];
  endfunction

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = !q_stat.full;
  assign accept       = in_if.valid && in_if.ready;
  assign b            = in_if.data_byte;
  assign nl           = (b == csvtok_pkg::CHAR_CR) || (b == csvtok_pkg::CHAR_LF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter            <= csvtok_pkg::RST_DELIMITER;
      cfg_r.quote_byte           <= csvtok_pkg::RST_QUOTE;
      cfg_r.escape_byte          <= csvtok_pkg::RST_ESCAPE;
      cfg_r.list_end_byte        <= csvtok_pkg::RST_LIST_END;
      cfg_r.allow_quoted_newline <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.reg_index)
        csvtok_pkg::CFG_DELIMITER: cfg_r.delimiter            <= cfg_if.wdata;
        csvtok_pkg::CFG_QUOTE:     cfg_r.quote_byte           <= cfg_if.wdata;
        csvtok_pkg::CFG_ESCAPE:    cfg_r.escape_byte          <= cfg_if.wdata;
        csvtok_pkg::CFG_LIST_END:  cfg_r.list_end_byte        <= cfg_if.wdata;
        csvtok_pkg::CFG_QUOTED_NL: cfg_r.allow_quoted_newline <= cfg_if.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csvtok_pkg::ST_VSTART;
      col_r   <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
    end
  end

  always_comb begin
    ws = state_r;
    wcol = col_r;
    // restart a row on the byte after a CR or after a skipped newline run
    if ((state_r == csvtok_pkg::ST_AFTER_CR && b != csvtok_pkg::CHAR_LF) ||
        (state_r == csvtok_pkg::ST_SKIP_NL && !nl)) begin
      ws   = csvtok_pkg::ST_VSTART;
      wcol = '0;
    end
    if (ws == csvtok_pkg::ST_VSTART && b != cfg_r.quote_byte) begin
      ws = csvtok_pkg::ST_NORMAL;
    end
  end

  assign wcol_inc = (wcol == COL_MAX) ? wcol : wcol + 1'b1;

  always_comb begin
    state_nxt        = ws;
    col_nxt          = wcol;
    emit             = 1'b0;
    req.two          = 1'b0;
    req.kind         = csvtok_pkg::KIND_CONTENT;
    req.content_byte = 8'd0;
    req.col0         = to_idx(wcol);
    req.err          = csvtok_pkg::ERR_NONE;
    req.col1         = to_idx(wcol_inc);
    if (in_if.is_end) begin
      state_nxt = csvtok_pkg::ST_VSTART;
      col_nxt   = '0;
      req.col0  = to_idx(col_r);
      req.col1  = to_idx((col_r == COL_MAX) ? col_r : col_r + 1'b1);
      case (state_r)
        csvtok_pkg::ST_NORMAL, csvtok_pkg::ST_UNQ: begin
          emit     = 1'b1;
          req.two  = 1'b1;
          req.kind = csvtok_pkg::KIND_FIELD_END;
        end
        csvtok_pkg::ST_VSTART: begin
          emit     = (col_r != '0);
          req.kind = csvtok_pkg::KIND_ROW_END;
        end
        csvtok_pkg::ST_INQ: begin
          emit     = 1'b1;
          req.kind = csvtok_pkg::KIND_ROW_ERROR;
          req.err  = csvtok_pkg::ERR_UNTERMINATED;
        end
        csvtok_pkg::ST_ESC: begin
          emit     = 1'b1;
          req.kind = csvtok_pkg::KIND_ROW_ERROR;
          req.err  = csvtok_pkg::ERR_ESCAPE_AT_END;
        end
        default: ;
      endcase
    end else begin
      case (ws)
        csvtok_pkg::ST_AFTER_CR: begin
          state_nxt = csvtok_pkg::ST_VSTART;
        end
        csvtok_pkg::ST_SKIP_LINE: begin
          if (nl) state_nxt = csvtok_pkg::ST_SKIP_NL;
        end
        csvtok_pkg::ST_VSTART: begin
          state_nxt = csvtok_pkg::ST_INQ;
        end
        csvtok_pkg::ST_NORMAL: begin
          emit = 1'b1;
          if (b == cfg_r.delimiter) begin
            req.kind  = csvtok_pkg::KIND_FIELD_END;
            col_nxt   = wcol_inc;
            state_nxt = csvtok_pkg::ST_VSTART;
          end else if (nl) begin
            req.kind  = csvtok_pkg::KIND_FIELD_END;
            req.two   = 1'b1;
            col_nxt   = '0;
            state_nxt = (b == csvtok_pkg::CHAR_CR) ? csvtok_pkg::ST_AFTER_CR
                                                   : csvtok_pkg::ST_VSTART;
          end else begin
            req.content_byte = b;
          end
        end
        csvtok_pkg::ST_INQ: begin
          if (b == cfg_r.quote_byte) begin
            state_nxt = csvtok_pkg::ST_UNQ;
          end else if (cfg_r.escape_byte != 8'd0 && b == cfg_r.escape_byte) begin
            state_nxt = csvtok_pkg::ST_ESC;
          end else if (nl && !cfg_r.allow_quoted_newline) begin
            emit      = 1'b1;
            req.kind  = csvtok_pkg::KIND_ROW_ERROR;
            req.err   = csvtok_pkg::ERR_QUOTED_NL;
            col_nxt   = '0;
            state_nxt = csvtok_pkg::ST_SKIP_NL;
          end else begin
            emit             = 1'b1;
            req.content_byte = b;
          end
        end
        csvtok_pkg::ST_UNQ: begin
          emit = 1'b1;
          if (b == cfg_r.quote_byte &&
              (cfg_r.escape_byte == 8'd0 || cfg_r.escape_byte == cfg_r.quote_byte)) begin
            req.content_byte = b;
            state_nxt        = csvtok_pkg::ST_INQ;
          end else if (b == cfg_r.delimiter || b == cfg_r.list_end_byte) begin
            req.kind  = csvtok_pkg::KIND_FIELD_END;
            col_nxt   = wcol_inc;
            state_nxt = csvtok_pkg::ST_VSTART;
          end else if (nl) begin
            req.kind  = csvtok_pkg::KIND_FIELD_END;
            req.two   = 1'b1;
            col_nxt   = '0;
            state_nxt = (b == csvtok_pkg::CHAR_CR) ? csvtok_pkg::ST_AFTER_CR
                                                   : csvtok_pkg::ST_VSTART;
          end else begin
            req.kind  = csvtok_pkg::KIND_ROW_ERROR;
            req.err   = csvtok_pkg::ERR_AFTER_QUOTE;
            col_nxt   = '0;
            state_nxt = csvtok_pkg::ST_SKIP_LINE;
          end
        end
        csvtok_pkg::ST_ESC: begin
          emit = 1'b1;
          if (b == cfg_r.quote_byte || b == cfg_r.escape_byte) begin
            req.content_byte = b;
            state_nxt        = csvtok_pkg::ST_INQ;
          end else begin
            req.kind  = csvtok_pkg::KIND_ROW_ERROR;
            req.err   = csvtok_pkg::ERR_BAD_ESCAPE;
            col_nxt   = '0;
            state_nxt = csvtok_pkg::ST_SKIP_LINE;
          end
        end
        default: ;
      endcase
    end
  end

  assign push     = accept && emit;
  assign push_req = req;

endmodule

>>> sv/csvtok_queue.sv
// ----------------------------------------------------------------------------
// csvtok_queue
// Small request queue between the parser and the token output stage.
// ----------------------------------------------------------------------------
module csvtok_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  csvtok_pkg::tok_req_t push_req,
  input  logic                 pop,
  output csvtok_pkg::tok_req_t head,
  output csvtok_pkg::q_stat_t  q_stat
);

  localparam int DEPTH = csvtok_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  csvtok_pkg::tok_req_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign do_pop = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_req;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  assign head         = mem[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

>>> sv/csvtok_back.sv
// ----------------------------------------------------------------------------
// csvtok_back
// Token output stage: splits a request into its tokens and holds each in
// the output register until taken.
// ----------------------------------------------------------------------------
module csvtok_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csvtok_pkg::tok_req_t head,
  input  csvtok_pkg::q_stat_t  q_stat,
  output logic                 pop,
  csvtok_out_if.source         out_if
);

  logic       out_valid_r, out_valid_nxt;
  logic       phase_r, phase_nxt;
  logic       load;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [9:0] col_r, col_nxt;
  logic [2:0] err_r, err_nxt;
  logic       last_r, last_nxt;

  assign load = !q_stat.empty && (!out_valid_r || out_if.ready);

  always_comb begin
    phase_nxt     = phase_r;
    pop           = 1'b0;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    col_nxt       = col_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (!phase_r) begin
        kind_nxt = head.kind;
        byte_nxt = head.content_byte;
        col_nxt  = head.col0;
        err_nxt  = head.err;
        last_nxt = !head.two;
        if (head.two) phase_nxt = 1'b1;
        else pop = 1'b1;
      end else begin
        kind_nxt  = csvtok_pkg::KIND_ROW_END;
        byte_nxt  = 8'd0;
        col_nxt   = head.col1;
        err_nxt   = csvtok_pkg::ERR_NONE;
        last_nxt  = 1'b1;
        phase_nxt = 1'b0;
        pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    col_r  <= col_nxt;
    err_r  <= err_nxt;
    last_r <= last_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = kind_r;
  assign out_if.content_byte = byte_r;
  assign out_if.column_index = col_r;
  assign out_if.error_code   = err_r;
  assign out_if.last_of_run  = last_r;

endmodule

>>> test/csv_field_tokenizer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer_core_tb
// Self-checking bench for the CSV field tokenizer. A short directed table walks
// quotes, escapes, newlines and end-of-file handling. Several register settings
// follow with random CSV records, noise and sender/receiver stalls. A predictor
// tracks parse state per accepted request and checks each token in order.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_core_tb;

  localparam int             HOLD_CYCLES    = 300;
  localparam int             QUIET_LIMIT    = 4000;
  localparam int             SETTLE_CYCLES  = 4;
  localparam int             DRAIN_CYCLES   = 10;
  localparam int             RANDOM_ITEMS   = 120;
  localparam logic [2:0]     CFG_UNUSED_IDX = 3'd7;
  localparam logic [7:0]     DQ             = 8'h22;
  localparam logic [7:0]     COMMA          = 8'h2C;
  localparam logic [7:0]     BSLASH         = 8'h5C;
  localparam logic [7:0]     TAB            = 8'h09;
  localparam logic [7:0]     RBRACKET       = 8'h5D;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

  typedef struct packed {
    csvtok_pkg::kind_t                kind;
    logic [7:0]                       content_byte;
    logic [csvtok_pkg::COL_IDX_W-1:0] column_index;
    csvtok_pkg::err_t                 error_code;
    logic                             last_of_run;
  } token_t;

  typedef struct packed {
    row_op_t    op;
    logic [2:0] reg_index;
    logic [7:0] data_byte;
    logic       is_end;
    logic       typed;
    logic [1:0] n_typed;
    token_t     t0;
    token_t     t1;
  } stim_row_t;

  localparam token_t NO_TOK = '0;

  logic clk = 1'b0;
  logic rst_n;

  csvtok_in_if  in_if();
  csvtok_out_if out_if();
  csvtok_cfg_if cfg_if();

  csv_field_tokenizer_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #4 clk = ~clk;

  // predictor state
  csvtok_pkg::pstate_t              p_state;
  logic [csvtok_pkg::COL_IDX_W-1:0] p_col;
  csvtok_pkg::cfg_t                 p_cfg;
  token_t                           run_tok [2];
  int                               run_n;

  token_t    pending_tokens [$];
  stim_row_t directed_rows [$];
  stim_row_t cur_row;
  int        errors;
  int        items_sent;
  int        snd_idle_pct;
  int        rcv_idle_pct;
  int        hold_requests;
  int        hold_served;
  int        hold_left;
  int        quiet_cycles;

  function automatic logic [csvtok_pkg::COL_IDX_W-1:0] col_next(
      logic [csvtok_pkg::COL_IDX_W-1:0] c);
    if (c < csvtok_pkg::CSVTOK_MAX_COLUMNS - 1) return c + 1'b1;
    return csvtok_pkg::COL_IDX_W'(csvtok_pkg::CSVTOK_MAX_COLUMNS - 1);
  endfunction

  function automatic bit is_newline(logic [7:0] b);
    return b == csvtok_pkg::CHAR_CR || b == csvtok_pkg::CHAR_LF;
  endfunction

  function automatic void expect_token(token_t t);
    pending_tokens.insert(pending_tokens.size(), t);
  endfunction

  function automatic void add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic void add_expected(csvtok_pkg::kind_t k, logic [7:0] cb,
                                       logic [csvtok_pkg::COL_IDX_W-1:0] col,
                                       csvtok_pkg::err_t er);
    if (run_n < 2) begin
      run_tok[run_n] = '{k, cb, col, er, 1'b0};
      run_n++;
    end
  endfunction

  function automatic void close_row(logic [7:0] b);
    add_expected(csvtok_pkg::KIND_FIELD_END, 8'h00, p_col, csvtok_pkg::ERR_NONE);
    add_expected(csvtok_pkg::KIND_ROW_END, 8'h00, col_next(p_col), csvtok_pkg::ERR_NONE);
    p_col = '0;
    p_state = (b == csvtok_pkg::CHAR_CR) ? csvtok_pkg::ST_AFTER_CR : csvtok_pkg::ST_VSTART;
  endfunction

  function automatic void raise_row_error(csvtok_pkg::err_t er, csvtok_pkg::pstate_t nxt);
    add_expected(csvtok_pkg::KIND_ROW_ERROR, 8'h00, p_col, er);
    p_col = '0;
    p_state = nxt;
  endfunction

  function automatic void predict_tokens(logic [7:0] b, logic e);
    bit again;
    run_n = 0;
    if (e) begin
      case (p_state)
        csvtok_pkg::ST_NORMAL, csvtok_pkg::ST_UNQ: begin
          add_expected(csvtok_pkg::KIND_FIELD_END, 8'h00, p_col, csvtok_pkg::ERR_NONE);
          add_expected(csvtok_pkg::KIND_ROW_END, 8'h00, col_next(p_col),
                       csvtok_pkg::ERR_NONE);
        end
        csvtok_pkg::ST_VSTART: if (p_col != 0)
          add_expected(csvtok_pkg::KIND_ROW_END, 8'h00, p_col, csvtok_pkg::ERR_NONE);
        csvtok_pkg::ST_INQ:
          add_expected(csvtok_pkg::KIND_ROW_ERROR, 8'h00, p_col, csvtok_pkg::ERR_UNTERMINATED);
        csvtok_pkg::ST_ESC:
          add_expected(csvtok_pkg::KIND_ROW_ERROR, 8'h00, p_col,
                       csvtok_pkg::ERR_ESCAPE_AT_END);
        default: ;
      endcase
      p_state = csvtok_pkg::ST_VSTART;
      p_col = '0;
    end else begin
      again = 1'b1;
      while (again) begin
        again = 1'b0;
        case (p_state)
          csvtok_pkg::ST_AFTER_CR: begin
            p_state = csvtok_pkg::ST_VSTART;
            again = (b != csvtok_pkg::CHAR_LF);
          end
          csvtok_pkg::ST_SKIP_LINE: if (is_newline(b)) p_state = csvtok_pkg::ST_SKIP_NL;
          csvtok_pkg::ST_SKIP_NL: if (!is_newline(b)) begin
            p_state = csvtok_pkg::ST_VSTART;
            p_col = '0;
            again = 1'b1;
          end
          csvtok_pkg::ST_VSTART: if (b == p_cfg.quote_byte) begin
            p_state = csvtok_pkg::ST_INQ;
          end else begin
            p_state = csvtok_pkg::ST_NORMAL;
            again = 1'b1;
          end
          csvtok_pkg::ST_NORMAL: if (b == p_cfg.delimiter) begin
            add_expected(csvtok_pkg::KIND_FIELD_END, 8'h00, p_col, csvtok_pkg::ERR_NONE);
            p_col = col_next(p_col);
            p_state = csvtok_pkg::ST_VSTART;
          end else if (is_newline(b)) begin
            close_row(b);
          end else begin
            add_expected(csvtok_pkg::KIND_CONTENT, b, p_col, csvtok_pkg::ERR_NONE);
          end
          csvtok_pkg::ST_INQ: if (b == p_cfg.quote_byte) begin
            p_state = csvtok_pkg::ST_UNQ;
          end else if (p_cfg.escape_byte != 0 && b == p_cfg.escape_byte) begin
            p_state = csvtok_pkg::ST_ESC;
          end else if (is_newline(b) && !p_cfg.allow_quoted_newline) begin
            raise_row_error(csvtok_pkg::ERR_QUOTED_NL, csvtok_pkg::ST_SKIP_NL);
          end else begin
            add_expected(csvtok_pkg::KIND_CONTENT, b, p_col, csvtok_pkg::ERR_NONE);
          end
          csvtok_pkg::ST_UNQ: if (b == p_cfg.quote_byte &&
                      (p_cfg.escape_byte == 0 || p_cfg.escape_byte == p_cfg.quote_byte)) begin
            add_expected(csvtok_pkg::KIND_CONTENT, b, p_col, csvtok_pkg::ERR_NONE);
            p_state = csvtok_pkg::ST_INQ;
          end else if (b == p_cfg.delimiter || b == p_cfg.list_end_byte) begin
            add_expected(csvtok_pkg::KIND_FIELD_END, 8'h00, p_col, csvtok_pkg::ERR_NONE);
            p_col = col_next(p_col);
            p_state = csvtok_pkg::ST_VSTART;
          end else if (is_newline(b)) begin
            close_row(b);
          end else begin
            raise_row_error(csvtok_pkg::ERR_AFTER_QUOTE, csvtok_pkg::ST_SKIP_LINE);
          end
          default: if (b == p_cfg.quote_byte || b == p_cfg.escape_byte) begin
            add_expected(csvtok_pkg::KIND_CONTENT, b, p_col, csvtok_pkg::ERR_NONE);
            p_state = csvtok_pkg::ST_INQ;
          end else begin
            raise_row_error(csvtok_pkg::ERR_BAD_ESCAPE, csvtok_pkg::ST_SKIP_LINE);
          end
        endcase
      end
    end
    if (run_n > 0) run_tok[run_n-1].last_of_run = 1'b1;
  endfunction

  function automatic token_t tok(csvtok_pkg::kind_t k, logic [7:0] cb,
                                 logic [csvtok_pkg::COL_IDX_W-1:0] col,
                                 csvtok_pkg::err_t er, logic last);
    return '{k, cb, col, er, last};
  endfunction

  function automatic stim_row_t byte_row(logic [7:0] b, logic e);
    return '{ROW_ITEM, 3'd0, b, e, 1'b0, 2'd0, NO_TOK, NO_TOK};
  endfunction

  function automatic stim_row_t typed_row(logic [7:0] b, logic e, logic [1:0] n, token_t t0,
                                          token_t t1);
    return '{ROW_ITEM, 3'd0, b, e, 1'b1, n, t0, t1};
  endfunction

  function automatic stim_row_t cfg_row(logic [2:0] idx, logic [7:0] v);
    return '{ROW_CFG, idx, v, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK};
  endfunction

  function automatic bit is_special(logic [7:0] b);
    return b == p_cfg.delimiter || b == p_cfg.quote_byte || b == p_cfg.escape_byte ||
           b == p_cfg.list_end_byte || is_newline(b);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_special(b));
    return b;
  endfunction

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 5))
      0: return p_cfg.delimiter;
      1: return p_cfg.quote_byte;
      2: return p_cfg.escape_byte;
      3: return p_cfg.list_end_byte;
      4: return csvtok_pkg::CHAR_CR;
      default: return csvtok_pkg::CHAR_LF;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    errors++;
  endtask

  task automatic put_item(stim_row_t row);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= row.data_byte;
    in_if.is_end <= row.is_end;
    cur_row <= row;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic put_byte(logic [7:0] b, logic e);
    put_item(byte_row(b, e));
  endtask

  // drop valid, drain all tokens, then let the pipeline settle
  task automatic go_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata <= v;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      csvtok_pkg::CFG_DELIMITER: p_cfg.delimiter = v;
      csvtok_pkg::CFG_QUOTE:     p_cfg.quote_byte = v;
      csvtok_pkg::CFG_ESCAPE:    p_cfg.escape_byte = v;
      csvtok_pkg::CFG_LIST_END:  p_cfg.list_end_byte = v;
      csvtok_pkg::CFG_QUOTED_NL: p_cfg.allow_quoted_newline = v[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(csvtok_pkg::cfg_t c);
    go_idle();
    write_reg(csvtok_pkg::CFG_DELIMITER, c.delimiter);
    write_reg(csvtok_pkg::CFG_QUOTE, c.quote_byte);
    write_reg(csvtok_pkg::CFG_ESCAPE, c.escape_byte);
    write_reg(csvtok_pkg::CFG_LIST_END, c.list_end_byte);
    write_reg(csvtok_pkg::CFG_QUOTED_NL, {7'd0, c.allow_quoted_newline});
    write_reg(CFG_UNUSED_IDX, 8'($urandom_range(0, 255)));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic put_field(bit quoted);
    if (!quoted) begin
      repeat ($urandom_range(0, 5)) put_byte(plain_byte(), 1'b0);
    end else begin
      put_byte(p_cfg.quote_byte, 1'b0);
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 5))
          2: put_byte(p_cfg.delimiter, 1'b0);
          3: begin
            put_byte((p_cfg.escape_byte == 0) ? p_cfg.quote_byte : p_cfg.escape_byte, 1'b0);
            put_byte(p_cfg.quote_byte, 1'b0);
          end
          4: if (p_cfg.escape_byte != 0) begin
            put_byte(p_cfg.escape_byte, 1'b0);
            put_byte(p_cfg.escape_byte, 1'b0);
          end else begin
            put_byte(plain_byte(), 1'b0);
          end
          5: put_byte(p_cfg.allow_quoted_newline ?
                      ($urandom_range(0, 1) ? csvtok_pkg::CHAR_CR : csvtok_pkg::CHAR_LF) :
                      plain_byte(), 1'b0);
          default: put_byte(plain_byte(), 1'b0);
        endcase
      end
      put_byte(p_cfg.quote_byte, 1'b0);
    end
  endtask

  task automatic put_record();
    int  nf;
    bit  quoted;
    nf = $urandom_range(1, 4);
    for (int i = 0; i < nf; i++) begin
      quoted = $urandom_range(0, 99) < 40;
      put_field(quoted);
      if (i < nf - 1)
        put_byte((quoted && $urandom_range(0, 3) == 0) ? p_cfg.list_end_byte : p_cfg.delimiter,
                 1'b0);
    end
    case ($urandom_range(0, 3))
      0: put_byte(csvtok_pkg::CHAR_CR, 1'b0);
      1: begin
        put_byte(csvtok_pkg::CHAR_CR, 1'b0);
        put_byte(csvtok_pkg::CHAR_LF, 1'b0);
      end
      default: put_byte(csvtok_pkg::CHAR_LF, 1'b0);
    endcase
  endtask

  task automatic run_random(int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      case ($urandom_range(0, 19))
        0: repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)), 1'b0);
        1: repeat ($urandom_range(1, 3)) put_byte(special_byte(), 1'b0);
        2: put_byte(8'($urandom_range(0, 255)), 1'b1);
        default: put_record();
      endcase
    end
    put_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic csvtok_pkg::cfg_t random_cfg();
    csvtok_pkg::cfg_t c;
    c.delimiter = 8'($urandom_range(0, 255));
    c.quote_byte = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: c.escape_byte = 8'h00;
      1: c.escape_byte = c.quote_byte;
      default: c.escape_byte = 8'($urandom_range(0, 255));
    endcase
    c.list_end_byte = 8'($urandom_range(0, 255));
    c.allow_quoted_newline = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // receiver: random stalls plus an occasional long hold
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_if.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    token_t exp_tok;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        predict_tokens(in_if.data_byte, in_if.is_end);
        if (cur_row.typed) begin
          if (cur_row.n_typed > 0) expect_token(cur_row.t0);
          if (cur_row.n_typed > 1) expect_token(cur_row.t1);
        end else begin
          for (int i = 0; i < run_n; i++) expect_token(run_tok[i]);
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_tokens.size() == 0) begin
          report_mismatch($sformatf("token kind %0d with nothing expected", out_if.kind));
        end else begin
          exp_tok = pending_tokens.pop_front();
          if (out_if.kind !== exp_tok.kind)
            report_mismatch($sformatf("kind exp %0d got %0d", exp_tok.kind, out_if.kind));
          if (out_if.content_byte !== exp_tok.content_byte)
            report_mismatch($sformatf("content_byte exp %02h got %02h",
                                      exp_tok.content_byte, out_if.content_byte));
          if (out_if.column_index !== exp_tok.column_index)
            report_mismatch($sformatf("column_index exp %0d got %0d",
                                      exp_tok.column_index, out_if.column_index));
          if (out_if.error_code !== exp_tok.error_code)
            report_mismatch($sformatf("error_code exp %0d got %0d",
                                      exp_tok.error_code, out_if.error_code));
          if (out_if.last_of_run !== exp_tok.last_of_run)
            report_mismatch($sformatf("last_of_run exp %0d got %0d",
                                      exp_tok.last_of_run, out_if.last_of_run));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.is_end = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = csvtok_pkg::CFG_DELIMITER;
    cfg_if.wdata = 8'h00;
    out_if.ready = 1'b0;
    cur_row = '0;
    errors = 0;
    items_sent = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    quiet_cycles = 0;
    p_state = csvtok_pkg::ST_VSTART;
    p_col = '0;
    p_cfg = '{csvtok_pkg::RST_DELIMITER, csvtok_pkg::RST_QUOTE, csvtok_pkg::RST_ESCAPE,
              csvtok_pkg::RST_LIST_END, 1'b0};
    snd_idle_pct = 29;
    rcv_idle_pct = 61;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    add_row(typed_row("a", 1'b0, 2'd1,
                      tok(csvtok_pkg::KIND_CONTENT, "a", 10'd0, csvtok_pkg::ERR_NONE, 1'b1),
                      NO_TOK));
    add_row(typed_row(COMMA, 1'b0, 2'd1,
                      tok(csvtok_pkg::KIND_FIELD_END, 8'd0, 10'd0, csvtok_pkg::ERR_NONE, 1'b1),
                      NO_TOK));
    add_row(typed_row(csvtok_pkg::CHAR_LF, 1'b0, 2'd2,
                      tok(csvtok_pkg::KIND_FIELD_END, 8'd0, 10'd1, csvtok_pkg::ERR_NONE, 1'b0),
                      tok(csvtok_pkg::KIND_ROW_END, 8'd0, 10'd2, csvtok_pkg::ERR_NONE, 1'b1)));
    add_row(typed_row(csvtok_pkg::CHAR_LF, 1'b0, 2'd2,
                      tok(csvtok_pkg::KIND_FIELD_END, 8'd0, 10'd0, csvtok_pkg::ERR_NONE, 1'b0),
                      tok(csvtok_pkg::KIND_ROW_END, 8'd0, 10'd1, csvtok_pkg::ERR_NONE, 1'b1)));
    add_row(typed_row(DQ, 1'b0, 2'd0, NO_TOK, NO_TOK));
    add_row(typed_row(DQ, 1'b0, 2'd0, NO_TOK, NO_TOK));
    add_row(typed_row(DQ, 1'b0, 2'd1,
                      tok(csvtok_pkg::KIND_CONTENT, DQ, 10'd0, csvtok_pkg::ERR_NONE, 1'b1),
                      NO_TOK));
    add_row(byte_row(DQ, 1'b0));
    add_row(byte_row(csvtok_pkg::CHAR_CR, 1'b0));
    add_row(byte_row(csvtok_pkg::CHAR_LF, 1'b0));
    add_row(byte_row("x", 1'b0));
    add_row(typed_row(DQ, 1'b0, 2'd1,
                      tok(csvtok_pkg::KIND_CONTENT, DQ, 10'd0, csvtok_pkg::ERR_NONE, 1'b1),
                      NO_TOK));
    add_row(byte_row(COMMA, 1'b0));
    add_row(byte_row(DQ, 1'b0));
    add_row(typed_row(csvtok_pkg::CHAR_LF, 1'b0, 2'd1,
                      tok(csvtok_pkg::KIND_ROW_ERROR, 8'd0, 10'd1, csvtok_pkg::ERR_QUOTED_NL,
                          1'b1),
                      NO_TOK));
    add_row(byte_row(csvtok_pkg::CHAR_CR, 1'b0));
    add_row(typed_row(8'h00, 1'b0, 2'd1,
                      tok(csvtok_pkg::KIND_CONTENT, 8'h00, 10'd0, csvtok_pkg::ERR_NONE, 1'b1),
                      NO_TOK));
    add_row(typed_row(8'hFF, 1'b0, 2'd1,
                      tok(csvtok_pkg::KIND_CONTENT, 8'hFF, 10'd0, csvtok_pkg::ERR_NONE, 1'b1),
                      NO_TOK));
    add_row(byte_row(COMMA, 1'b0));
    add_row(typed_row(8'h00, 1'b1, 2'd1,
                      tok(csvtok_pkg::KIND_ROW_END, 8'd0, 10'd1, csvtok_pkg::ERR_NONE, 1'b1),
                      NO_TOK));
    add_row(byte_row(DQ, 1'b0));
    add_row(typed_row(8'hFF, 1'b1, 2'd1,
                      tok(csvtok_pkg::KIND_ROW_ERROR, 8'd0, 10'd0,
                          csvtok_pkg::ERR_UNTERMINATED, 1'b1),
                      NO_TOK));
    add_row(cfg_row(csvtok_pkg::CFG_ESCAPE, BSLASH));
    add_row(byte_row(DQ, 1'b0));
    add_row(byte_row(BSLASH, 1'b0));
    add_row(typed_row("k", 1'b0, 2'd1,
                      tok(csvtok_pkg::KIND_ROW_ERROR, 8'd0, 10'd0, csvtok_pkg::ERR_BAD_ESCAPE,
                          1'b1),
                      NO_TOK));
    add_row(byte_row(csvtok_pkg::CHAR_LF, 1'b0));
    add_row(byte_row(DQ, 1'b0));
    add_row(byte_row(BSLASH, 1'b0));
    add_row(typed_row(8'h00, 1'b1, 2'd1,
                      tok(csvtok_pkg::KIND_ROW_ERROR, 8'd0, 10'd0,
                          csvtok_pkg::ERR_ESCAPE_AT_END, 1'b1),
                      NO_TOK));
    add_row(byte_row(DQ, 1'b0));
    add_row(byte_row(DQ, 1'b0));
    add_row(typed_row(DQ, 1'b0, 2'd1,
                      tok(csvtok_pkg::KIND_ROW_ERROR, 8'd0, 10'd0, csvtok_pkg::ERR_AFTER_QUOTE,
                          1'b1),
                      NO_TOK));
    add_row(byte_row(8'h00, 1'b1));
    add_row(cfg_row(CFG_UNUSED_IDX, 8'hFF));
    add_row(cfg_row(csvtok_pkg::CFG_QUOTED_NL, 8'h01));
    add_row(byte_row(DQ, 1'b0));
    add_row(byte_row(csvtok_pkg::CHAR_LF, 1'b0));
    add_row(byte_row(DQ, 1'b0));
    add_row(typed_row(RBRACKET, 1'b0, 2'd1,
                      tok(csvtok_pkg::KIND_FIELD_END, 8'd0, 10'd0, csvtok_pkg::ERR_NONE, 1'b1),
                      NO_TOK));
    add_row(byte_row(8'h00, 1'b1));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CFG) begin
        go_idle();
        write_reg(directed_rows[i].reg_index, directed_rows[i].data_byte);
        cfg_if.valid <= 1'b0;
      end else begin
        put_item(directed_rows[i]);
      end
    end

    program_regs('{csvtok_pkg::RST_DELIMITER, csvtok_pkg::RST_QUOTE, csvtok_pkg::RST_ESCAPE,
                   csvtok_pkg::RST_LIST_END, 1'b0});
    run_random(RANDOM_ITEMS);
    program_regs('{8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1});
    run_random(RANDOM_ITEMS);

    snd_idle_pct = 61;
    rcv_idle_pct = 29;
    program_regs(random_cfg());
    run_random(RANDOM_ITEMS);
    program_regs('{TAB, DQ, BSLASH, RBRACKET, 1'b1});
    run_random(RANDOM_ITEMS);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    program_regs('{8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0});
    hold_requests++;
    run_random(RANDOM_ITEMS);
    program_regs('{csvtok_pkg::RST_DELIMITER, csvtok_pkg::RST_QUOTE, csvtok_pkg::RST_ESCAPE,
                   csvtok_pkg::RST_LIST_END, 1'b0});
    // overflow the column index within one row
    repeat (csvtok_pkg::CSVTOK_MAX_COLUMNS + 6) put_byte(p_cfg.delimiter, 1'b0);
    put_byte(csvtok_pkg::CHAR_LF, 1'b0);
    hold_requests++;
    run_random(RANDOM_ITEMS);

    go_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
